// ----- hw/rtl/rshc_pkg.sv -----
// shared types, codes and constants of the remote start heater controller
`default_nettype none

package rshc_pkg;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CfgBattLowLimit   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgBattStartLimit = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgTempThreshold  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgChoiceHigh     = 8'd3;
  localparam logic [CfgIdxW-1:0] CfgChoiceLow      = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgStartWindow    = 8'd5;
  localparam logic [CfgIdxW-1:0] CfgVerifyWindow   = 8'd6;
  localparam logic [CfgIdxW-1:0] CfgRestartDelay   = 8'd7;

  localparam logic [7:0] TmrOff      = 8'hFF;
  localparam logic [7:0] OffDelay    = 8'h10;
  localparam logic [7:0] ChoiceSplit = 8'h7F;

  localparam logic [7:0] RstBattLowLimit   = 8'h80;
  localparam logic [7:0] RstBattStartLimit = 8'h93;
  localparam logic [7:0] RstTempThreshold  = 8'hEE;
  localparam logic [7:0] RstChoiceHigh     = 8'h84;
  localparam logic [7:0] RstChoiceLow      = 8'h7B;
  localparam logic [7:0] RstStartWindow    = 8'h04;
  localparam logic [7:0] RstVerifyWindow   = 8'h10;
  localparam logic [7:0] RstRestartDelay   = 8'h10;

  typedef enum logic [2:0] {
    ENG_OFF      = 3'd0,
    ENG_TOSTART  = 3'd1,
    ENG_STARTING = 3'd2,
    ENG_REMOTE   = 3'd3,
    ENG_KEY      = 3'd4,
    ENG_ERR      = 3'd5
  } eng_e;

  typedef enum logic [2:0] {
    HT_OFF      = 3'd0,
    HT_TOSTART  = 3'd1,
    HT_STARTING = 3'd2,
    HT_ON       = 3'd3,
    HT_ERR      = 3'd4
  } ht_e;

  typedef struct packed {
    logic [7:0] batt_low_limit;
    logic [7:0] batt_start_limit;
    logic [7:0] temp_threshold;
    logic [7:0] choice_high;
    logic [7:0] choice_low;
    logic [7:0] start_window;
    logic [7:0] verify_window;
    logic [7:0] restart_delay;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic       ign_on;
    logic       key_ign_on;
    logic       heater_running;
    logic       stop_line;
    logic       start_line;
    logic [7:0] battery_level;
    logic [7:0] engine_temp;
  } item_t;

  typedef struct packed {
    eng_e       eng;
    ht_e        ht;
    logic [7:0] ht_tmr;
    logic [7:0] eng_tmr;
    logic [7:0] rem_tmr;
    logic [7:0] off_tmr;
    logic [7:0] bat_hold;
    logic [7:0] choice;
    logic       relay;
    logic       auto_st;
    logic       alert_sent;
    logic       err_logged;
    logic       stop_test;
  } st_t;

  typedef struct packed {
    logic [2:0] engine_mode;
    logic [2:0] heater_mode;
    logic       heater_relay;
    logic       starter_pulse;
    logic       alert_pulse;
    logic       log_request;
  } res_t;

  function automatic logic all_idle(st_t s);
    return (s.ht == HT_OFF) && (s.eng == ENG_OFF) && (s.rem_tmr == TmrOff) &&
           (s.ht_tmr == TmrOff) && (s.eng_tmr == TmrOff);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rshc_cfg.sv -----
// configuration register file
`default_nettype none

module rshc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rshc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i,
  output rshc_pkg::cfg_t                     cfg_o
);

  rshc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.batt_low_limit   <= rshc_pkg::RstBattLowLimit;
      cfg_q.batt_start_limit <= rshc_pkg::RstBattStartLimit;
      cfg_q.temp_threshold   <= rshc_pkg::RstTempThreshold;
      cfg_q.choice_high      <= rshc_pkg::RstChoiceHigh;
      cfg_q.choice_low       <= rshc_pkg::RstChoiceLow;
      cfg_q.start_window     <= rshc_pkg::RstStartWindow;
      cfg_q.verify_window    <= rshc_pkg::RstVerifyWindow;
      cfg_q.restart_delay    <= rshc_pkg::RstRestartDelay;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rshc_pkg::CfgBattLowLimit:   cfg_q.batt_low_limit   <= cfg_data_i;
        rshc_pkg::CfgBattStartLimit: cfg_q.batt_start_limit <= cfg_data_i;
        rshc_pkg::CfgTempThreshold:  cfg_q.temp_threshold   <= cfg_data_i;
        rshc_pkg::CfgChoiceHigh:     cfg_q.choice_high      <= cfg_data_i;
        rshc_pkg::CfgChoiceLow:      cfg_q.choice_low       <= cfg_data_i;
        rshc_pkg::CfgStartWindow:    cfg_q.start_window     <= cfg_data_i;
        rshc_pkg::CfgVerifyWindow:   cfg_q.verify_window    <= cfg_data_i;
        rshc_pkg::CfgRestartDelay:   cfg_q.restart_delay    <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rshc_step.sv -----
// next-state and result logic for one item
`default_nettype none

module rshc_step #(
  parameter int unsigned BATTERY_HOLD_TICKS = 7
) (
  input  wire rshc_pkg::cfg_t  cfg_i,
  input  wire rshc_pkg::item_t item_i,
  input  wire rshc_pkg::st_t   st_i,
  output rshc_pkg::st_t        st_o,
  output rshc_pkg::res_t       res_o
);

  localparam logic [7:0] HoldMark = 8'(255 - BATTERY_HOLD_TICKS);

  rshc_pkg::st_t s;
  logic p_start, p_alert, p_log;

  always_comb begin
    s       = st_i;
    p_start = 1'b0;
    p_alert = 1'b0;
    p_log   = 1'b0;

    if (item_i.req_type) begin
      // tick
      if (s.ht_tmr != rshc_pkg::TmrOff) begin
        s.ht_tmr = 8'(s.ht_tmr - 8'd1);
        if (s.ht_tmr == 8'd0) begin
          s.ht     = rshc_pkg::HT_ERR;
          s.ht_tmr = rshc_pkg::TmrOff;
        end
      end
      if (s.eng_tmr != rshc_pkg::TmrOff) begin
        s.eng_tmr = 8'(s.eng_tmr - 8'd1);
        if (s.eng == rshc_pkg::ENG_OFF) begin
          s.eng     = rshc_pkg::ENG_ERR;
          s.eng_tmr = rshc_pkg::TmrOff;
        end
        if (s.eng_tmr == 8'd0) begin
          if (s.eng != rshc_pkg::ENG_KEY && s.eng != rshc_pkg::ENG_REMOTE) begin
            s.eng = rshc_pkg::ENG_ERR;
          end
          s.eng_tmr = rshc_pkg::TmrOff;
        end
      end
      if (s.rem_tmr != rshc_pkg::TmrOff) begin
        s.rem_tmr = 8'(s.rem_tmr - 8'd1);
      end
      if (s.off_tmr != rshc_pkg::TmrOff) begin
        s.off_tmr = 8'(s.off_tmr - 8'd1);
      end

      if (rshc_pkg::all_idle(s)) begin
        if (item_i.battery_level > cfg_i.batt_low_limit &&
            item_i.battery_level <= cfg_i.batt_start_limit) begin
          if (s.bat_hold > HoldMark) begin
            s.bat_hold = 8'(s.bat_hold - 8'd1);
          end
        end else if (s.bat_hold != rshc_pkg::TmrOff) begin
          s.bat_hold = 8'(s.bat_hold + 8'd1);
        end
      end else begin
        s.bat_hold = rshc_pkg::TmrOff;
      end

      if (item_i.engine_temp < cfg_i.temp_threshold) begin
        if (s.choice < cfg_i.choice_high) begin
          s.choice = 8'(s.choice + 8'd1);
        end
      end else if (s.choice > cfg_i.choice_low) begin
        if (s.choice == cfg_i.choice_high && !s.alert_sent &&
            s.eng == rshc_pkg::ENG_OFF && s.ht == rshc_pkg::HT_OFF) begin
          p_alert      = 1'b1;
          s.alert_sent = 1'b1;
          p_log        = 1'b1;
        end
        s.choice = 8'(s.choice - 8'd1);
      end
    end else begin
      // pin evaluation
      if (item_i.key_ign_on && (s.ht == rshc_pkg::HT_ERR || s.eng == rshc_pkg::ENG_ERR)) begin
        s.ht  = rshc_pkg::HT_OFF;
        s.eng = rshc_pkg::ENG_OFF;
      end
      if (!(s.ht == rshc_pkg::HT_ERR || s.eng == rshc_pkg::ENG_ERR)) begin
        if (item_i.ign_on) begin
          s.rem_tmr = rshc_pkg::TmrOff;
          if (!s.auto_st) begin
            s.alert_sent = 1'b0;
          end
          if (item_i.key_ign_on) begin
            if (s.eng != rshc_pkg::ENG_KEY && s.eng != rshc_pkg::ENG_REMOTE &&
                s.off_tmr == rshc_pkg::TmrOff) begin
              s.eng_tmr = cfg_i.verify_window;
            end
            s.eng = rshc_pkg::ENG_KEY;
            if (s.eng_tmr == cfg_i.verify_window) begin
              p_log = 1'b1;
            end
            s.auto_st    = 1'b0;
            s.alert_sent = 1'b0;
          end else begin
            if (s.eng == rshc_pkg::ENG_STARTING) begin
              s.eng_tmr = cfg_i.verify_window;
            end
            s.eng = rshc_pkg::ENG_REMOTE;
            if (s.eng_tmr == cfg_i.verify_window) begin
              p_log = 1'b1;
            end
          end
        end else if (s.eng != rshc_pkg::ENG_STARTING && s.eng != rshc_pkg::ENG_TOSTART &&
                     s.eng != rshc_pkg::ENG_OFF) begin
          s.off_tmr = rshc_pkg::OffDelay;
          s.eng     = rshc_pkg::ENG_OFF;
        end

        if (item_i.heater_running) begin
          if (s.ht != rshc_pkg::HT_ON) begin
            s.ht_tmr  = rshc_pkg::TmrOff;
            s.rem_tmr = rshc_pkg::TmrOff;
            s.ht      = rshc_pkg::HT_ON;
            p_log     = 1'b1;
          end
        end else if (s.ht == rshc_pkg::HT_ON) begin
          s.rem_tmr = cfg_i.restart_delay;
          s.ht_tmr  = rshc_pkg::TmrOff;
          s.ht      = rshc_pkg::HT_OFF;
          s.relay   = 1'b0;
          p_log     = 1'b1;
        end

        if (!item_i.stop_line) begin
          if (s.eng != rshc_pkg::ENG_KEY && s.choice >= rshc_pkg::ChoiceSplit) begin
            s.stop_test = 1'b1;
          end
        end else if (s.stop_test) begin
          s.stop_test = 1'b0;
          p_alert     = 1'b1;
        end

        if (!item_i.start_line) begin
          if (rshc_pkg::all_idle(s)) begin
            s.auto_st = 1'b0;
            if (s.choice <= rshc_pkg::ChoiceSplit) begin
              s.ht     = rshc_pkg::HT_TOSTART;
              s.ht_tmr = cfg_i.start_window;
            end else begin
              s.eng     = rshc_pkg::ENG_TOSTART;
              s.eng_tmr = cfg_i.start_window;
            end
          end
        end else begin
          if (s.ht == rshc_pkg::HT_TOSTART) begin
            s.relay  = 1'b1;
            s.ht_tmr = cfg_i.start_window;
            s.ht     = rshc_pkg::HT_STARTING;
            p_log    = 1'b1;
          end
          if (s.eng == rshc_pkg::ENG_TOSTART) begin
            s.eng     = rshc_pkg::ENG_STARTING;
            s.eng_tmr = cfg_i.start_window;
            p_start   = 1'b1;
            p_log     = 1'b1;
          end
        end

        // delayed remote start after heater stop
        if (s.rem_tmr == 8'd0) begin
          s.rem_tmr = rshc_pkg::TmrOff;
          if (s.eng == rshc_pkg::ENG_OFF && s.ht == rshc_pkg::HT_OFF) begin
            s.eng     = rshc_pkg::ENG_STARTING;
            s.eng_tmr = cfg_i.start_window;
            p_start   = 1'b1;
            p_log     = 1'b1;
          end
        end

        // low battery autostart
        if (s.bat_hold == HoldMark && rshc_pkg::all_idle(s)) begin
          s.auto_st = 1'b1;
          if (s.choice <= rshc_pkg::ChoiceSplit) begin
            s.relay  = 1'b1;
            s.ht_tmr = cfg_i.start_window;
            s.ht     = rshc_pkg::HT_STARTING;
            p_log    = 1'b1;
          end else begin
            s.eng     = rshc_pkg::ENG_STARTING;
            s.eng_tmr = cfg_i.start_window;
            p_start   = 1'b1;
            p_log     = 1'b1;
          end
        end
      end
    end

    // error check
    if (s.eng == rshc_pkg::ENG_ERR || s.ht == rshc_pkg::HT_ERR) begin
      s.relay = 1'b0;
      if (!s.err_logged) begin
        p_log        = 1'b1;
        s.err_logged = 1'b1;
      end
    end else if (s.err_logged) begin
      p_log        = 1'b1;
      s.err_logged = 1'b0;
    end
  end

  assign st_o                = s;
  assign res_o.engine_mode   = 3'(s.eng);
  assign res_o.heater_mode   = 3'(s.ht);
  assign res_o.heater_relay  = s.relay;
  assign res_o.starter_pulse = p_start;
  assign res_o.alert_pulse   = p_alert;
  assign res_o.log_request   = p_log;

endmodule

`default_nettype wire

// ----- hw/rtl/remote_start_heater_controller_core.sv -----
// top level of the remote start heater controller
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o  req_type .. engine_temp
//   out      out  out_valid_o/out_stall_i engine_mode .. log_request
//   cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle while the result is not stalled; an accepted item passes the input
// register, then the result register, with the single-pass state update between them
// reset clears state, timers to stopped, and configuration to defaults
// a stalled result holds; the input register still takes one more item
// state advances only when an item moves into the result register
`default_nettype none

module remote_start_heater_controller_core #(
  parameter int unsigned BATTERY_HOLD_TICKS = 7
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [rshc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                   cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         req_type_i,
  input  wire logic                         ign_on_i,
  input  wire logic                         key_ign_on_i,
  input  wire logic                         heater_running_i,
  input  wire logic                         stop_line_i,
  input  wire logic                         start_line_i,
  input  wire logic [7:0]                   battery_level_i,
  input  wire logic [7:0]                   engine_temp_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [2:0]                        engine_mode_o,
  output logic [2:0]                        heater_mode_o,
  output logic                              heater_relay_o,
  output logic                              starter_pulse_o,
  output logic                              alert_pulse_o,
  output logic                              log_request_o
);

  rshc_pkg::cfg_t  cfg;
  rshc_pkg::item_t item_q;
  rshc_pkg::st_t   st_q, st_d;
  rshc_pkg::res_t  res_q, res_d;
  logic            in_vld_q, out_vld_q;
  logic            adv, in_take;

  rshc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rshc_step #(
    .BATTERY_HOLD_TICKS (BATTERY_HOLD_TICKS)
  ) u_step (
    .cfg_i  (cfg),
    .item_i (item_q),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q.eng        <= rshc_pkg::ENG_OFF;
      st_q.ht         <= rshc_pkg::HT_OFF;
      st_q.ht_tmr     <= rshc_pkg::TmrOff;
      st_q.eng_tmr    <= rshc_pkg::TmrOff;
      st_q.rem_tmr    <= rshc_pkg::TmrOff;
      st_q.off_tmr    <= rshc_pkg::TmrOff;
      st_q.bat_hold   <= rshc_pkg::TmrOff;
      st_q.choice     <= rshc_pkg::RstChoiceHigh;
      st_q.relay      <= 1'b0;
      st_q.auto_st    <= 1'b0;
      st_q.alert_sent <= 1'b0;
      st_q.err_logged <= 1'b0;
      st_q.stop_test  <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.req_type       <= req_type_i;
      item_q.ign_on         <= ign_on_i;
      item_q.key_ign_on     <= key_ign_on_i;
      item_q.heater_running <= heater_running_i;
      item_q.stop_line      <= stop_line_i;
      item_q.start_line     <= start_line_i;
      item_q.battery_level  <= battery_level_i;
      item_q.engine_temp    <= engine_temp_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign engine_mode_o   = res_q.engine_mode;
  assign heater_mode_o   = res_q.heater_mode;
  assign heater_relay_o  = res_q.heater_relay;
  assign starter_pulse_o = res_q.starter_pulse;
  assign alert_pulse_o   = res_q.alert_pulse;
  assign log_request_o   = res_q.log_request;

  a_err_relay_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (engine_mode_o == 3'(rshc_pkg::ENG_ERR) ||
                    heater_mode_o == 3'(rshc_pkg::HT_ERR)) |-> !heater_relay_o)
    else $error("heater relay driven in error");

  a_pulse_starting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && starter_pulse_o |-> engine_mode_o == 3'(rshc_pkg::ENG_STARTING))
    else $error("starter pulse without engine starting");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(st_q))
    else $error("state changed without an item");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// testbench for the remote start heater controller core
`timescale 1ns / 100ps

module tb;

  localparam int         HoldTicks    = 7;
  localparam logic [7:0] HoldMark     = 8'(255 - HoldTicks);
  localparam int         CycleLimit   = 600000;
  localparam int         SettleCycles = 8;
  localparam logic       ReqPins      = 1'b0;
  localparam logic       ReqTick      = 1'b1;

  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         cfg_valid_i      = 1'b0;
  logic                         cfg_ready_o;
  logic [rshc_pkg::CfgIdxW-1:0] cfg_index_i      = '0;
  logic [7:0]                   cfg_data_i       = '0;
  logic                         in_valid_i       = 1'b0;
  logic                         in_stall_o;
  logic                         req_type_i       = 1'b0;
  logic                         ign_on_i         = 1'b0;
  logic                         key_ign_on_i     = 1'b0;
  logic                         heater_running_i = 1'b0;
  logic                         stop_line_i      = 1'b1;
  logic                         start_line_i     = 1'b1;
  logic [7:0]                   battery_level_i  = '0;
  logic [7:0]                   engine_temp_i    = '0;
  logic                         out_valid_o;
  logic                         out_stall_i      = 1'b0;
  logic [2:0]                   engine_mode_o;
  logic [2:0]                   heater_mode_o;
  logic                         heater_relay_o;
  logic                         starter_pulse_o;
  logic                         alert_pulse_o;
  logic                         log_request_o;

  remote_start_heater_controller_core #(
    .BATTERY_HOLD_TICKS(HoldTicks)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .ign_on_i        (ign_on_i),
    .key_ign_on_i    (key_ign_on_i),
    .heater_running_i(heater_running_i),
    .stop_line_i     (stop_line_i),
    .start_line_i    (start_line_i),
    .battery_level_i (battery_level_i),
    .engine_temp_i   (engine_temp_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .engine_mode_o   (engine_mode_o),
    .heater_mode_o   (heater_mode_o),
    .heater_relay_o  (heater_relay_o),
    .starter_pulse_o (starter_pulse_o),
    .alert_pulse_o   (alert_pulse_o),
    .log_request_o   (log_request_o)
  );

  // controller state mirror
  rshc_pkg::eng_e eng_st;
  rshc_pkg::ht_e  ht_st;
  logic [7:0]     ht_tmr, eng_tmr, rem_tmr, off_tmr, bat_hold, choice;
  logic           relay, auto_st, alert_done, err_logged, stop_armed;
  logic           f_start, f_alert, f_log;
  rshc_pkg::cfg_t cfg_now;

  rshc_pkg::res_t pending[$];
  int   mismatches = 0;
  int   cycles     = 0;
  logic calm       = 1'b0;
  int   hold_left  = 0;
  int   stall_left = 0;

  always #5 clk_i = ~clk_i;

  function automatic logic units_idle();
    return ht_st == rshc_pkg::HT_OFF && eng_st == rshc_pkg::ENG_OFF &&
           rem_tmr == rshc_pkg::TmrOff && ht_tmr == rshc_pkg::TmrOff &&
           eng_tmr == rshc_pkg::TmrOff;
  endfunction

  function automatic void launch_engine();
    eng_st  = rshc_pkg::ENG_STARTING;
    eng_tmr = cfg_now.start_window;
    f_start = 1'b1;
    f_log   = 1'b1;
  endfunction

  function automatic void launch_heater();
    relay  = 1'b1;
    ht_tmr = cfg_now.start_window;
    ht_st  = rshc_pkg::HT_STARTING;
    f_log  = 1'b1;
  endfunction

  function automatic void predict_item(input rshc_pkg::item_t it);
    rshc_pkg::res_t r;
    f_start = 1'b0;
    f_alert = 1'b0;
    f_log   = 1'b0;
    if (it.req_type == ReqTick) begin
      if (ht_tmr != rshc_pkg::TmrOff) begin
        ht_tmr = ht_tmr - 8'd1;
        if (ht_tmr == 8'd0) begin
          ht_st  = rshc_pkg::HT_ERR;
          ht_tmr = rshc_pkg::TmrOff;
        end
      end
      if (eng_tmr != rshc_pkg::TmrOff) begin
        eng_tmr = eng_tmr - 8'd1;
        if (eng_st == rshc_pkg::ENG_OFF) begin
          eng_st  = rshc_pkg::ENG_ERR;
          eng_tmr = rshc_pkg::TmrOff;
        end
        if (eng_tmr == 8'd0) begin
          if (eng_st != rshc_pkg::ENG_KEY && eng_st != rshc_pkg::ENG_REMOTE)
            eng_st = rshc_pkg::ENG_ERR;
          eng_tmr = rshc_pkg::TmrOff;
        end
      end
      if (rem_tmr != rshc_pkg::TmrOff) rem_tmr = rem_tmr - 8'd1;
      if (off_tmr != rshc_pkg::TmrOff) off_tmr = off_tmr - 8'd1;
      if (units_idle()) begin
        if (it.battery_level > cfg_now.batt_low_limit &&
            it.battery_level <= cfg_now.batt_start_limit) begin
          if (bat_hold > HoldMark) bat_hold = bat_hold - 8'd1;
        end else if (bat_hold != rshc_pkg::TmrOff) begin
          bat_hold = bat_hold + 8'd1;
        end
      end else begin
        bat_hold = rshc_pkg::TmrOff;
      end
      if (it.engine_temp < cfg_now.temp_threshold) begin
        if (choice < cfg_now.choice_high) choice = choice + 8'd1;
      end else if (choice > cfg_now.choice_low) begin
        if (choice == cfg_now.choice_high && !alert_done &&
            eng_st == rshc_pkg::ENG_OFF && ht_st == rshc_pkg::HT_OFF) begin
          f_alert    = 1'b1;
          alert_done = 1'b1;
          f_log      = 1'b1;
        end
        choice = choice - 8'd1;
      end
    end else begin
      if (it.key_ign_on && (ht_st == rshc_pkg::HT_ERR || eng_st == rshc_pkg::ENG_ERR)) begin
        ht_st  = rshc_pkg::HT_OFF;
        eng_st = rshc_pkg::ENG_OFF;
      end
      if (!(ht_st == rshc_pkg::HT_ERR || eng_st == rshc_pkg::ENG_ERR)) begin
        if (it.ign_on) begin
          rem_tmr = rshc_pkg::TmrOff;
          if (!auto_st) alert_done = 1'b0;
          if (it.key_ign_on) begin
            if (eng_st != rshc_pkg::ENG_KEY && eng_st != rshc_pkg::ENG_REMOTE &&
                off_tmr == rshc_pkg::TmrOff)
              eng_tmr = cfg_now.verify_window;
            eng_st = rshc_pkg::ENG_KEY;
            if (eng_tmr == cfg_now.verify_window) f_log = 1'b1;
            auto_st    = 1'b0;
            alert_done = 1'b0;
          end else begin
            if (eng_st == rshc_pkg::ENG_STARTING) eng_tmr = cfg_now.verify_window;
            eng_st = rshc_pkg::ENG_REMOTE;
            if (eng_tmr == cfg_now.verify_window) f_log = 1'b1;
          end
        end else if (eng_st != rshc_pkg::ENG_STARTING && eng_st != rshc_pkg::ENG_TOSTART &&
                     eng_st != rshc_pkg::ENG_OFF) begin
          off_tmr = rshc_pkg::OffDelay;
          eng_st  = rshc_pkg::ENG_OFF;
        end

        if (it.heater_running) begin
          if (ht_st != rshc_pkg::HT_ON) begin
            ht_tmr  = rshc_pkg::TmrOff;
            rem_tmr = rshc_pkg::TmrOff;
            ht_st   = rshc_pkg::HT_ON;
            f_log   = 1'b1;
          end
        end else if (ht_st == rshc_pkg::HT_ON) begin
          rem_tmr = cfg_now.restart_delay;
          ht_tmr  = rshc_pkg::TmrOff;
          ht_st   = rshc_pkg::HT_OFF;
          relay   = 1'b0;
          f_log   = 1'b1;
        end

        if (!it.stop_line) begin
          if (eng_st != rshc_pkg::ENG_KEY && choice >= rshc_pkg::ChoiceSplit)
            stop_armed = 1'b1;
        end else if (stop_armed) begin
          stop_armed = 1'b0;
          f_alert    = 1'b1;
        end

        if (!it.start_line) begin
          if (units_idle()) begin
            auto_st = 1'b0;
            if (choice <= rshc_pkg::ChoiceSplit) begin
              ht_st  = rshc_pkg::HT_TOSTART;
              ht_tmr = cfg_now.start_window;
            end else begin
              eng_st  = rshc_pkg::ENG_TOSTART;
              eng_tmr = cfg_now.start_window;
            end
          end
        end else begin
          if (ht_st == rshc_pkg::HT_TOSTART) launch_heater();
          if (eng_st == rshc_pkg::ENG_TOSTART) launch_engine();
        end

        if (rem_tmr == 8'd0) begin
          rem_tmr = rshc_pkg::TmrOff;
          if (eng_st == rshc_pkg::ENG_OFF && ht_st == rshc_pkg::HT_OFF) launch_engine();
        end

        if (bat_hold == HoldMark && units_idle()) begin
          auto_st = 1'b1;
          if (choice <= rshc_pkg::ChoiceSplit) launch_heater();
          else launch_engine();
        end
      end
    end

    if (eng_st == rshc_pkg::ENG_ERR || ht_st == rshc_pkg::HT_ERR) begin
      relay = 1'b0;
      if (!err_logged) begin
        f_log      = 1'b1;
        err_logged = 1'b1;
      end
    end else if (err_logged) begin
      f_log      = 1'b1;
      err_logged = 1'b0;
    end

    r.engine_mode   = eng_st;
    r.heater_mode   = ht_st;
    r.heater_relay  = relay;
    r.starter_pulse = f_start;
    r.alert_pulse   = f_alert;
    r.log_request   = f_log;
    pending.push_back(r);
  endfunction

  function automatic rshc_pkg::item_t mk_item(input logic req, input logic ign,
                                              input logic key, input logic heat,
                                              input logic stop, input logic start,
                                              input logic [7:0] batt,
                                              input logic [7:0] temp);
    rshc_pkg::item_t it;
    it.req_type       = req;
    it.ign_on         = ign;
    it.key_ign_on     = key;
    it.heater_running = heat;
    it.stop_line      = stop;
    it.start_line     = start;
    it.battery_level  = batt;
    it.engine_temp    = temp;
    return it;
  endfunction

  task automatic send_item(input rshc_pkg::item_t it);
    @(negedge clk_i);
    in_valid_i       = 1'b1;
    req_type_i       = it.req_type;
    ign_on_i         = it.ign_on;
    key_ign_on_i     = it.key_ign_on;
    heater_running_i = it.heater_running;
    stop_line_i      = it.stop_line;
    start_line_i     = it.start_line;
    battery_level_i  = it.battery_level;
    engine_temp_i    = it.engine_temp;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(it);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [rshc_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    unique case (idx)
      rshc_pkg::CfgBattLowLimit:   cfg_now.batt_low_limit   = val;
      rshc_pkg::CfgBattStartLimit: cfg_now.batt_start_limit = val;
      rshc_pkg::CfgTempThreshold:  cfg_now.temp_threshold   = val;
      rshc_pkg::CfgChoiceHigh:     cfg_now.choice_high      = val;
      rshc_pkg::CfgChoiceLow:      cfg_now.choice_low       = val;
      rshc_pkg::CfgStartWindow:    cfg_now.start_window     = val;
      rshc_pkg::CfgVerifyWindow:   cfg_now.verify_window    = val;
      rshc_pkg::CfgRestartDelay:   cfg_now.restart_delay    = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input rshc_pkg::cfg_t c);
    wait_idle();
    cfg_write(rshc_pkg::CfgBattLowLimit, c.batt_low_limit);
    cfg_write(rshc_pkg::CfgBattStartLimit, c.batt_start_limit);
    cfg_write(rshc_pkg::CfgTempThreshold, c.temp_threshold);
    cfg_write(rshc_pkg::CfgChoiceHigh, c.choice_high);
    cfg_write(rshc_pkg::CfgChoiceLow, c.choice_low);
    cfg_write(rshc_pkg::CfgStartWindow, c.start_window);
    cfg_write(rshc_pkg::CfgVerifyWindow, c.verify_window);
    cfg_write(rshc_pkg::CfgRestartDelay, c.restart_delay);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_battery_autostart();
    repeat (HoldTicks)
      send_item(mk_item(ReqTick, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd140, 8'd250));
    send_item(mk_item(ReqPins, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd140, 8'd250));
  endtask

  task automatic test_engine_cycle();
    send_item(mk_item(ReqPins, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0));
    send_item(mk_item(ReqPins, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0));
    send_item(mk_item(ReqTick, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0));
    send_item(mk_item(ReqPins, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0));
    send_item(mk_item(ReqPins, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0));
  endtask

  task automatic test_heater_and_lines();
    send_item(mk_item(ReqPins, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0));
    send_item(mk_item(ReqPins, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0));
    send_item(mk_item(ReqPins, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 8'd0));
    send_item(mk_item(ReqPins, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0));
    send_item(mk_item(ReqPins, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0));
    send_item(mk_item(ReqPins, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0));
    send_item(mk_item(ReqTick, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255));
    send_item(mk_item(ReqPins, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0));
    send_item(mk_item(ReqTick, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0));
  endtask

  // receiver holds off while items keep coming, then the sender waits for a full drain
  task automatic test_backpressure();
    logic [$bits(rshc_pkg::item_t)-1:0] raw;
    hold_left = 300;
    repeat (40) begin
      raw = $bits(rshc_pkg::item_t)'($urandom);
      send_item(raw);
    end
    wait_idle();
    repeat (10) begin
      raw = $bits(rshc_pkg::item_t)'($urandom);
      send_item(raw);
    end
    wait_idle();
  endtask

  task automatic test_random(input int n, input rshc_pkg::cfg_t c, input logic quiet);
    rshc_pkg::item_t                    it;
    logic [$bits(rshc_pkg::item_t)-1:0] raw;
    int                                 lo, hi, thr;
    logic                               busy, in_err;
    load_config(c);
    calm = quiet;
    repeat (n) begin
      if (!calm && $urandom_range(0, 9) == 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
      busy   = (eng_st == rshc_pkg::ENG_STARTING || eng_st == rshc_pkg::ENG_REMOTE ||
                eng_st == rshc_pkg::ENG_KEY);
      in_err = (eng_st == rshc_pkg::ENG_ERR || ht_st == rshc_pkg::HT_ERR);
      it.req_type       = ($urandom_range(0, 9) < 4) ? ReqTick : ReqPins;
      it.ign_on         = busy ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) == 0);
      it.key_ign_on     = in_err ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 15) == 0);
      it.heater_running = (ht_st == rshc_pkg::HT_STARTING || ht_st == rshc_pkg::HT_ON) ?
                          ($urandom_range(0, 9) < 8) : ($urandom_range(0, 19) == 0);
      it.stop_line      = ($urandom_range(0, 11) != 0);
      it.start_line     = ($urandom_range(0, 7) != 0);
      lo  = int'(cfg_now.batt_low_limit);
      hi  = int'(cfg_now.batt_start_limit);
      thr = int'(cfg_now.temp_threshold);
      if (lo < hi && $urandom_range(0, 9) < 6) it.battery_level = 8'($urandom_range(lo + 1, hi));
      else it.battery_level = 8'($urandom_range(0, 255));
      if (thr > 0 && $urandom_range(0, 1) == 1) it.engine_temp = 8'($urandom_range(0, thr - 1));
      else it.engine_temp = 8'($urandom_range(thr, 255));
      if ($urandom_range(0, 9) == 0) begin
        raw = $bits(rshc_pkg::item_t)'($urandom);
        it  = raw;
      end
      send_item(it);
    end
    wait_idle();
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left   = hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left  = stall_left - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_stall_i = 1'b1;
      stall_left  = $urandom_range(0, 15);
    end else begin
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_check
    rshc_pkg::res_t want, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{engine_mode_o, heater_mode_o, heater_relay_o, starter_pulse_o,
              alert_pulse_o, log_request_o};
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("tb: unexpected result eng=%0d ht=%0d relay=%0b start=%0b alert=%0b log=%0b",
                   got.engine_mode, got.heater_mode, got.heater_relay, got.starter_pulse,
                   got.alert_pulse, got.log_request);
        mismatches = mismatches + 1;
      end else begin
        want = pending.pop_front();
        if (got.engine_mode !== want.engine_mode || got.heater_mode !== want.heater_mode ||
            got.heater_relay !== want.heater_relay ||
            got.starter_pulse !== want.starter_pulse ||
            got.alert_pulse !== want.alert_pulse || got.log_request !== want.log_request) begin
          if (mismatches < 10)
            $display({"tb: mismatch exp eng=%0d ht=%0d relay=%0b start=%0b alert=%0b log=%0b",
                      " got eng=%0d ht=%0d relay=%0b start=%0b alert=%0b log=%0b"},
                     want.engine_mode, want.heater_mode, want.heater_relay,
                     want.starter_pulse, want.alert_pulse, want.log_request,
                     got.engine_mode, got.heater_mode, got.heater_relay,
                     got.starter_pulse, got.alert_pulse, got.log_request);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rshc_pkg::cfg_t c;
    cfg_now = '{rshc_pkg::RstBattLowLimit, rshc_pkg::RstBattStartLimit,
                rshc_pkg::RstTempThreshold, rshc_pkg::RstChoiceHigh,
                rshc_pkg::RstChoiceLow, rshc_pkg::RstStartWindow,
                rshc_pkg::RstVerifyWindow, rshc_pkg::RstRestartDelay};
    eng_st     = rshc_pkg::ENG_OFF;
    ht_st      = rshc_pkg::HT_OFF;
    ht_tmr     = rshc_pkg::TmrOff;
    eng_tmr    = rshc_pkg::TmrOff;
    rem_tmr    = rshc_pkg::TmrOff;
    off_tmr    = rshc_pkg::TmrOff;
    bat_hold   = rshc_pkg::TmrOff;
    choice     = rshc_pkg::RstChoiceHigh;
    relay      = 1'b0;
    auto_st    = 1'b0;
    alert_done = 1'b0;
    err_logged = 1'b0;
    stop_armed = 1'b0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_battery_autostart();
    test_engine_cycle();
    test_heater_and_lines();
    test_backpressure();

    test_random(330, cfg_now, 1'b0);
    test_random(330, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1}, 1'b0);
    test_random(330, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254},
                1'b0);
    test_random(330, '{8'd100, 8'd200, 8'd128, 8'd140, 8'd20, 8'd3, 8'd5, 8'd2}, 1'b0);
    test_random(330, '{8'd200, 8'd100, 8'd50, 8'd10, 8'd200, 8'd2, 8'd3, 8'd1}, 1'b0);
    c.batt_low_limit   = 8'($urandom_range(0, 200));
    c.batt_start_limit = 8'($urandom_range(0, 255));
    c.temp_threshold   = 8'($urandom_range(0, 255));
    c.choice_high      = 8'($urandom_range(100, 160));
    c.choice_low       = 8'($urandom_range(90, 140));
    c.start_window     = 8'($urandom_range(1, 12));
    c.verify_window    = 8'($urandom_range(1, 12));
    c.restart_delay    = 8'($urandom_range(1, 12));
    test_random(330, c, 1'b1);

    wait_idle();
    if (mismatches == 0 && pending.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
